/* rtl/drd_pkg.sv */
// ----------------------------------------------------------------------------
// Display reply deframer package
// Shared sizes, marker bytes, frame kinds and the control/status structures
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package drd_pkg;

  // Frame store size and derived widths.
  localparam int FRAME_DEPTH = 32;
  localparam int PTR_W       = $clog2(FRAME_DEPTH);
  localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);

  // Fixed field widths of the channels.
  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;
  localparam int LEN_W  = 6;

  // Marker bytes of the display protocol.
  localparam logic [BYTE_W-1:0] BUTTON_MARK = 8'h5F;
  localparam logic [BYTE_W-1:0] COORD_MARK  = 8'h2D;
  localparam logic [BYTE_W-1:0] ANSWER_MARK = 8'hFF;

  // An answer frame ends when a third FF follows two stored ones.
  localparam logic [1:0] FF_RUN_MAX = 2'd2;

  // Frame kinds as reported on the result channel.
  localparam logic [KIND_W-1:0] KIND_BUTTON = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COORD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ANSWER = 2'd2;

  // What the newest byte does to the store.
  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_BUTTON,
    CLS_COORD,
    CLS_ANSWER
  } drd_cls_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;       // input transfer this cycle
    logic code_rd;    // read the first byte of an answer frame
    logic code_ld;    // capture that byte as the response code
    logic emit_rd;    // read the next frame byte into the result register
    logic emit_mark;  // present the coordinate marker result
  } drd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    drd_cls_t cls;        // classification of the byte on the input channel
    logic     slot_free;  // result register is empty or being taken
    logic     rem_one;    // one frame byte is left to emit
  } drd_stat_t;

  // Next position in the circular frame store.
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(FRAME_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

/* rtl/drd_if.sv */
// ----------------------------------------------------------------------------
// Display reply deframer channels
// Valid/ready channels for received bytes and for deframed results.
// ----------------------------------------------------------------------------

// Received byte channel.
interface drd_in_if
  import drd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel.
interface drd_out_if
  import drd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] frame_kind;
  logic [BYTE_W-1:0] echo_byte;
  logic              echo_valid;
  logic [LEN_W-1:0]  frame_length;
  logic [BYTE_W-1:0] response_code;
  logic              last;

  modport source (output valid, output frame_kind, output echo_byte, output echo_valid,
                  output frame_length, output response_code, output last,
                  input ready);
  modport sink   (input valid, input frame_kind, input echo_byte, input echo_valid,
                  input frame_length, input response_code, input last,
                  output ready);
endinterface

/* rtl/drd_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module drd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/drd_ctrl.sv */
// ----------------------------------------------------------------------------
// Display reply deframer controller
// Sequences byte intake, the response code fetch and frame emission.
// ----------------------------------------------------------------------------
module drd_ctrl
  import drd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  drd_stat_t stat,
  output drd_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_CODE_RD = 5'b00010,
    S_CODE_LD = 5'b00100,
    S_EMIT    = 5'b01000,
    S_MARK    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Bytes are taken only between frames.
  assign in_ready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid) begin
          case (stat.cls)
            CLS_BUTTON: state_nxt = S_EMIT;
            CLS_COORD:  state_nxt = S_MARK;
            CLS_ANSWER: state_nxt = S_CODE_RD;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_CODE_RD: begin
        if (stat.slot_free) begin
          cmd.code_rd = 1'b1;
          state_nxt   = S_CODE_LD;
        end
      end
      S_CODE_LD: begin
        cmd.code_ld = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (stat.slot_free) begin
          cmd.emit_rd = 1'b1;
          if (stat.rem_one) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_MARK: begin
        if (stat.slot_free) begin
          cmd.emit_mark = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // An answer terminator always leads to the response code fetch.
  a_answer_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take && stat.cls == CLS_ANSWER |=> state_r == S_CODE_RD)
    else $error("answer frame did not start the code fetch");

  // The code capture always directly follows its read.
  a_code_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.code_ld |-> $past(cmd.code_rd))
    else $error("response code captured without a read");
`endif

endmodule

/* rtl/drd_datapath.sv */
// ----------------------------------------------------------------------------
// Display reply deframer datapath
// Circular frame store, terminator detection, frame read-out and the
// result register.
// ----------------------------------------------------------------------------
module drd_datapath
  import drd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  drd_cmd_t          cmd,
  output drd_stat_t         stat,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [KIND_W-1:0] out_frame_kind,
  output logic [BYTE_W-1:0] out_echo_byte,
  output logic              out_echo_valid,
  output logic [LEN_W-1:0]  out_frame_length,
  output logic [BYTE_W-1:0] out_response_code,
  output logic              out_last
);

  // Store bookkeeping.
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [1:0]        ff_run_r, ff_run_nxt;
  logic [BYTE_W-1:0] last_code_r, last_code_nxt;

  // Frame being emitted.
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;

  // Result register (the echo byte sits in the RAM read register).
  logic              out_valid_r, out_valid_nxt;
  logic              out_last_r, out_last_nxt;
  logic [KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;

  logic              full;
  logic [CNT_W-1:0]  n_after;
  logic [PTR_W-1:0]  head_adv;
  drd_cls_t          cls;
  logic [BYTE_W-1:0] ram_rdata;

  // A full store drops its oldest byte to make room.
  assign full     = (fill_r == CNT_W'(FRAME_DEPTH));
  assign n_after  = full ? fill_r : fill_r + 1'b1;
  assign head_adv = full ? ptr_inc(head_r) : head_r;

  // Terminator detection on the newest byte; earlier bytes never hold one.
  always_comb begin
    if (in_byte == BUTTON_MARK) begin
      cls = CLS_BUTTON;
    end else if (in_byte == COORD_MARK) begin
      cls = CLS_COORD;
    end else if (in_byte == ANSWER_MARK && ff_run_r == FF_RUN_MAX) begin
      cls = CLS_ANSWER;
    end else begin
      cls = CLS_NONE;
    end
  end

  assign stat.cls       = cls;
  assign stat.slot_free = !out_valid_r || out_ready;
  assign stat.rem_one   = (rem_r == CNT_W'(1));

  // Next values.
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    ff_run_nxt    = ff_run_r;
    last_code_nxt = last_code_r;
    rd_ptr_nxt    = rd_ptr_r;
    rem_nxt       = rem_r;
    kind_nxt      = kind_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    out_kind_nxt  = out_kind_r;
    out_len_nxt   = out_len_r;

    // Byte intake: append, and on a terminator hand the whole store to read-out.
    if (cmd.take) begin
      tail_nxt = ptr_inc(tail_r);
      if (cls == CLS_NONE) begin
        head_nxt = head_adv;
        fill_nxt = n_after;
        if (in_byte == ANSWER_MARK) begin
          ff_run_nxt = (ff_run_r == FF_RUN_MAX) ? FF_RUN_MAX : ff_run_r + 1'b1;
        end else begin
          ff_run_nxt = '0;
        end
      end else begin
        head_nxt   = ptr_inc(tail_r);
        fill_nxt   = '0;
        ff_run_nxt = '0;
        rd_ptr_nxt = head_adv;
        rem_nxt    = n_after;
        case (cls)
          CLS_BUTTON: kind_nxt = KIND_BUTTON;
          CLS_COORD:  kind_nxt = KIND_COORD;
          default:    kind_nxt = KIND_ANSWER;
        endcase
        if (cls == CLS_ANSWER) begin
          len_nxt = LEN_W'(n_after - CNT_W'(3));
        end else begin
          len_nxt = LEN_W'(n_after - CNT_W'(1));
        end
      end
    end

    // A non-empty answer frame updates the response code.
    if (cmd.code_ld && len_r != '0) begin
      last_code_nxt = ram_rdata;
    end

    // Result register load and drain.
    if (cmd.emit_rd) begin
      rd_ptr_nxt    = ptr_inc(rd_ptr_r);
      rem_nxt       = rem_r - 1'b1;
      out_valid_nxt = 1'b1;
      out_last_nxt  = (rem_r == CNT_W'(1));
      out_kind_nxt  = kind_r;
      out_len_nxt   = len_r;
    end else if (cmd.emit_mark) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = 1'b1;
      out_kind_nxt  = kind_r;
      out_len_nxt   = len_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      ff_run_r    <= '0;
      last_code_r <= '0;
      rd_ptr_r    <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      ff_run_r    <= ff_run_nxt;
      last_code_r <= last_code_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    len_r      <= len_nxt;
    out_kind_r <= out_kind_nxt;
    out_len_r  <= out_len_nxt;
  end

  // Frame store.
  drd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FRAME_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.take),
    .waddr (tail_r),
    .wdata (in_byte),
    .re    (cmd.emit_rd || cmd.code_rd),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  // Result fields; the coordinate marker carries no echo byte.
  assign out_valid         = out_valid_r;
  assign out_last          = out_last_r;
  assign out_frame_kind    = out_kind_r;
  assign out_frame_length  = out_len_r;
  assign out_response_code = last_code_r;
  assign out_echo_valid    = (out_kind_r != KIND_COORD);
  assign out_echo_byte     = (out_kind_r == KIND_COORD) ? '0 : ram_rdata;

`ifndef NO_ASSERTIONS
  // The store never holds more than its depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(FRAME_DEPTH))
    else $error("frame store overfilled");

  // No read-out past the end of a frame, and the final byte is flagged last.
  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_rd |-> rem_r != '0)
    else $error("frame read-out past its end");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_rd && rem_r == CNT_W'(1) |=> out_valid_r && out_last_r)
    else $error("final frame byte not marked last");

  // The code fetch never disturbs a result still waiting.
  a_code_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.code_ld |-> !out_valid_r)
    else $error("response code fetch overlapped a pending result");
`endif

endmodule

/* rtl/display_reply_deframer_core.sv */
// ----------------------------------------------------------------------------
// Display reply deframer
// Collects bytes from a display serial link into a frame store and emits
// button, coordinate and answer frames as results.
//
//   Channel  Dir  Payload                                       Transfer
//   in_chan  in   rx_byte                                       valid && ready
//   out_chan out  frame_kind, echo_byte, echo_valid,            valid && ready
//                 frame_length, response_code, last
//
// A byte that completes no frame is only stored. Button frames, and answer
// frames after the response code fetch, are read out through the single read
// port of the store, one echoed byte a cycle unless the result channel stalls.
// Reset clears the store's fill count and sets the response code to zero.
// A stalled result channel holds read-out; no new byte is taken until the
// last read of a frame has been issued.
// ----------------------------------------------------------------------------
module display_reply_deframer_core
  import drd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  drd_in_if.sink     in_chan,
  drd_out_if.source  out_chan
);

  drd_cmd_t  cmd;
  drd_stat_t stat;
  logic      in_ready;

  assign in_chan.ready = in_ready;

  // Controller.
  drd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath.
  drd_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_byte           (in_chan.rx_byte),
    .out_ready         (out_chan.ready),
    .out_valid         (out_chan.valid),
    .out_frame_kind    (out_chan.frame_kind),
    .out_echo_byte     (out_chan.echo_byte),
    .out_echo_valid    (out_chan.echo_valid),
    .out_frame_length  (out_chan.frame_length),
    .out_response_code (out_chan.response_code),
    .out_last          (out_chan.last)
  );

endmodule
